// ===== hw/rtl/source_char_tokenizer_top_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; files that assert include it by its bare file name.
`ifndef SOURCE_CHAR_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_CHAR_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sct_pkg.sv =====
// Package for the source character tokenizer: codes, token record, helpers.
// No dependencies; imported by source_char_tokenizer_top.
package sct_pkg;

    localparam int MAX_LINE_LEN = 4096;
    localparam int MAX_LINES    = 65536;

    localparam int COL_W  = 13;
    localparam int LINE_W = 16;

    localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(MAX_LINE_LEN);
    localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_LINES - 1);

    // request types
    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_EOL  = 2'd1;
    localparam logic [1:0] REQ_EOF  = 2'd2;

    // token kinds
    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_FUN    = 4'd1;
    localparam logic [3:0] KIND_RETURN = 4'd2;
    localparam logic [3:0] KIND_INT    = 4'd3;
    localparam logic [3:0] KIND_FLOAT  = 4'd4;
    localparam logic [3:0] KIND_ARROW  = 4'd5;
    localparam logic [3:0] KIND_LPAREN = 4'd6;
    localparam logic [3:0] KIND_RPAREN = 4'd7;
    localparam logic [3:0] KIND_LBRACE = 4'd8;
    localparam logic [3:0] KIND_RBRACE = 4'd9;
    localparam logic [3:0] KIND_SEMI   = 4'd10;
    localparam logic [3:0] KIND_COMMA  = 4'd11;
    localparam logic [3:0] KIND_EOF    = 4'd12;
    localparam logic [3:0] KIND_ERROR  = 4'd13;
    localparam logic [3:0] KIND_NONE   = 4'd0;  // punct lookup miss

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_CHAR = 2'd1;
    localparam logic [1:0] ERR_DOT  = 2'd2;

    // characters with a meaning of their own
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // keyword tracker: identifier length (saturating) and two live flags
    typedef struct packed {
        logic       ret_ok;
        logic       fun_ok;
        logic [2:0] len;
    } t_kwp;

    localparam t_kwp KWP_RESET = '{ret_ok: 1'b1, fun_ok: 1'b1, len: 3'd0};

    typedef struct packed {
        logic [3:0]        kind;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  first;
        logic [COL_W-1:0]  last;
        logic [1:0]        err;
        logic              last_of_run;
    } t_tok;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        case (c)
            CH_LPAREN: return KIND_LPAREN;
            CH_RPAREN: return KIND_RPAREN;
            CH_LBRACE: return KIND_LBRACE;
            CH_RBRACE: return KIND_RBRACE;
            CH_SEMI:   return KIND_SEMI;
            CH_COMMA:  return KIND_COMMA;
            default:   return KIND_NONE;
        endcase
    endfunction

    // letter of "fun" at a position; zero past the end never matches a letter
    function automatic logic [7:0] fun_char(input logic [2:0] pos);
        case (pos)
            3'd0:    return 8'h66;
            3'd1:    return 8'h75;
            3'd2:    return 8'h6E;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ret_char(input logic [2:0] pos);
        case (pos)
            3'd0:    return 8'h72;
            3'd1:    return 8'h65;
            3'd2:    return 8'h74;
            3'd3:    return 8'h75;
            3'd4:    return 8'h72;
            3'd5:    return 8'h6E;
            default: return 8'h00;
        endcase
    endfunction

    function automatic t_kwp kw_feed(input t_kwp p, input logic [7:0] c);
        t_kwp r;
        r = p;
        if (!(p.len < 3'd3 && c == fun_char(p.len))) r.fun_ok = 1'b0;
        if (!(p.len < 3'd6 && c == ret_char(p.len))) r.ret_ok = 1'b0;
        if (p.len != 3'd7) r.len = p.len + 3'd1;
        return r;
    endfunction

    function automatic logic [3:0] kw_kind(input t_kwp p);
        if (p.fun_ok && p.len == 3'd3) return KIND_FUN;
        if (p.ret_ok && p.len == 3'd6) return KIND_RETURN;
        return KIND_IDENT;
    endfunction

    function automatic t_tok mk_tok(input logic [3:0] kind, input logic [LINE_W-1:0] line,
                                    input logic [COL_W-1:0] first,
                                    input logic [COL_W-1:0] last, input logic [1:0] err);
        t_tok t;
        t.kind        = kind;
        t.line        = line;
        t.first       = first;
        t.last        = last;
        t.err         = err;
        t.last_of_run = 1'b0;
        return t;
    endfunction

endpackage

// ===== hw/rtl/source_char_tokenizer_top.sv =====
// Source character tokenizer: streaming lexer, one request per cycle unless stalled.
// Depends on sct_pkg and source_char_tokenizer_top_defines.svh.
//
//  channel   | valid   | ready   | payload
//  ----------+---------+---------+-----------------------------------------------
//  request   | i_valid | o_ready | i_req_type, i_char_code
//  token     | o_valid | i_ready | o_token_kind, o_line_index, o_first_col,
//            |         |         | o_last_col, o_error_code, o_last_of_run
//
// Flow: a request lands in the input register, is lexed from there and its
// tokens enter a four-entry token queue, whose head drives the token channel.
// One request per cycle is sustained while each request yields at most one
// token and i_ready stays high; the single output port sets that figure, so a
// request that closes one token and opens another leaves two tokens to send.
// Reset: synchronous, active low; clears the lexer state and the queue, no
// clearing pass. Stalls: the lexer takes the held request only while the queue
// has room for two tokens; otherwise it holds the request and drops o_ready.
`include "source_char_tokenizer_top_defines.svh"

module source_char_tokenizer_top
    import sct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_char_code,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_token_kind,
    output logic [LINE_W-1:0] o_line_index,
    output logic [COL_W-1:0]  o_first_col,
    output logic [COL_W-1:0]  o_last_col,
    output logic [1:0]        o_error_code,
    output logic              o_last_of_run
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_MINUS,
        MODE_HALTED
    } t_mode;

    // lexer state
    t_mode             r_mode,  n_mode;
    logic [COL_W-1:0]  r_start, n_start;
    logic [COL_W-1:0]  r_col,   n_col;
    logic [LINE_W-1:0] r_line,  n_line;
    t_kwp              r_kwp,   n_kwp;
    logic              r_dot,   n_dot;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_req;
    logic [7:0] r_in_char;

    // token queue, head at entry 0
    t_tok       r_q [4];
    t_tok       n_q [4];
    logic [2:0] r_cnt, n_cnt;

    logic w_proc;   // lex the held request this cycle
    logic w_pop;    // head token taken downstream

    // tokens caused by the held request
    t_tok       w_res [2];
    logic [1:0] w_nres;

    // start of a new token at the current column
    t_mode      w_st_mode;
    logic       w_st_mark;
    t_kwp       w_st_kwp;
    logic       w_st_has;
    t_tok       w_st_tok;
    logic [3:0] w_pk;
    t_tok       w_pend;

    assign o_valid = (r_cnt != 3'd0);
    assign w_pop   = o_valid && i_ready;
    // two free slots guarantee room for the worst case of two tokens
    assign w_proc  = r_in_valid && (r_cnt <= 3'd2);
    assign o_ready = !r_in_valid || w_proc;

    assign o_token_kind  = r_q[0].kind;
    assign o_line_index  = r_q[0].line;
    assign o_first_col   = r_q[0].first;
    assign o_last_col    = r_q[0].last;
    assign o_error_code  = r_q[0].err;
    assign o_last_of_run = r_q[0].last_of_run;

    // What a character does when no token is open: start one, emit a
    // single-character token, skip whitespace, or fail.
    always_comb begin
        w_pk      = punct_kind(r_in_char);
        w_st_mode = MODE_IDLE;
        w_st_mark = 1'b0;
        w_st_kwp  = r_kwp;
        w_st_has  = 1'b0;
        w_st_tok  = mk_tok(KIND_ERROR, r_line, r_col, r_col + 13'd1, ERR_CHAR);
        if (is_space(r_in_char)) begin
            w_st_mode = MODE_IDLE;
        end else if (is_alpha(r_in_char)) begin
            w_st_mode = MODE_IDENT;
            w_st_mark = 1'b1;
            w_st_kwp  = kw_feed(KWP_RESET, r_in_char);
        end else if (is_digit(r_in_char)) begin
            w_st_mode = MODE_NUMBER;
            w_st_mark = 1'b1;
        end else if (r_in_char == CH_MINUS) begin
            w_st_mode = MODE_MINUS;
            w_st_mark = 1'b1;
        end else if (w_pk != KIND_NONE) begin
            w_st_has = 1'b1;
            w_st_tok = mk_tok(w_pk, r_line, r_col, r_col + 13'd1, ERR_NONE);
        end else begin
            w_st_mode = MODE_HALTED;
            w_st_has  = 1'b1;
        end
    end

    // Pending identifier or number, closed at the current column.
    always_comb begin
        if (r_mode == MODE_IDENT) begin
            w_pend = mk_tok(kw_kind(r_kwp), r_line, r_start, r_col, ERR_NONE);
        end else begin
            w_pend = mk_tok(r_dot ? KIND_FLOAT : KIND_INT, r_line, r_start, r_col, ERR_NONE);
        end
    end

    // Lexer step for the held request.
    always_comb begin : lex_step
        logic do_start;
        t_tok min_err;
        do_start = 1'b0;
        min_err  = mk_tok(KIND_ERROR, r_line, r_start, r_start + 13'd1, ERR_CHAR);
        n_mode   = r_mode;
        n_start  = r_start;
        n_col    = r_col;
        n_line   = r_line;
        n_kwp    = r_kwp;
        n_dot    = r_dot;
        w_res[0] = '0;
        w_res[1] = '0;
        w_nres   = 2'd0;

        if (w_proc) begin
            case (r_in_req)
                REQ_CHAR: begin
                    if (r_mode != MODE_HALTED) begin
                        case (r_mode)
                            MODE_IDLE: begin
                                do_start = 1'b1;
                            end
                            MODE_IDENT: begin
                                if (is_alpha(r_in_char) || is_digit(r_in_char)) begin
                                    n_kwp = kw_feed(r_kwp, r_in_char);
                                end else begin
                                    w_res[0] = w_pend;
                                    w_nres   = 2'd1;
                                    do_start = 1'b1;
                                end
                            end
                            MODE_NUMBER: begin
                                if (is_digit(r_in_char)) begin
                                    n_dot = r_dot;
                                end else if (r_in_char == CH_DOT) begin
                                    if (r_dot) begin
                                        w_res[0] = mk_tok(KIND_ERROR, r_line, r_col,
                                                          r_col + 13'd1, ERR_DOT);
                                        w_nres   = 2'd1;
                                        n_mode   = MODE_HALTED;
                                    end else begin
                                        n_dot = 1'b1;
                                    end
                                end else begin
                                    w_res[0] = w_pend;
                                    w_nres   = 2'd1;
                                    do_start = 1'b1;
                                end
                            end
                            MODE_MINUS: begin
                                if (r_in_char == CH_GT) begin
                                    w_res[0] = mk_tok(KIND_ARROW, r_line, r_start,
                                                      r_col + 13'd1, ERR_NONE);
                                    n_mode   = MODE_IDLE;
                                end else begin
                                    // lone minus: report it and drop this character
                                    w_res[0] = min_err;
                                    n_mode   = MODE_HALTED;
                                end
                                w_nres = 2'd1;
                            end
                            default: begin
                                n_mode = r_mode;
                            end
                        endcase

                        if (do_start) begin
                            n_mode = w_st_mode;
                            if (w_st_mark) n_start = r_col;
                            if (w_st_mode == MODE_IDENT) n_kwp = w_st_kwp;
                            if (w_st_mode == MODE_NUMBER) n_dot = 1'b0;
                            if (w_st_has) begin
                                w_res[w_nres[0]] = w_st_tok;
                                w_nres = w_nres + 2'd1;
                            end
                        end

                        // hold the column at its ceiling on long lines
                        if (r_col < COL_MAX) n_col = r_col + 13'd1;
                    end
                end
                REQ_EOL: begin
                    if (r_mode == MODE_MINUS) begin
                        w_res[0] = min_err;
                        w_nres   = 2'd1;
                        n_mode   = MODE_HALTED;
                    end else if (r_mode != MODE_HALTED) begin
                        if (r_mode == MODE_IDENT || r_mode == MODE_NUMBER) begin
                            w_res[0] = w_pend;
                            w_nres   = 2'd1;
                        end
                        n_mode = MODE_IDLE;
                        if (r_line < LINE_MAX) n_line = r_line + 16'd1;
                        n_col = '0;
                    end
                end
                REQ_EOF: begin
                    if (r_mode == MODE_MINUS) begin
                        w_res[0] = min_err;
                        w_nres   = 2'd1;
                    end else if (r_mode == MODE_IDENT || r_mode == MODE_NUMBER) begin
                        w_res[0] = w_pend;
                        w_nres   = 2'd1;
                    end
                    w_res[w_nres[0]] = mk_tok(KIND_EOF, '0, '0, '0, ERR_NONE);
                    w_nres  = w_nres + 2'd1;
                    // next request starts a fresh file
                    n_mode  = MODE_IDLE;
                    n_start = '0;
                    n_col   = '0;
                    n_line  = '0;
                    n_kwp   = KWP_RESET;
                    n_dot   = 1'b0;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase

            if (w_nres != 2'd0) w_res[w_nres[1]].last_of_run = 1'b1;
        end
    end

    // Queue update: shift on pop, append this cycle's tokens behind the rest.
    always_comb begin : queue_next
        logic [2:0] base;
        base = r_cnt - {2'b00, w_pop};
        for (int i = 0; i < 4; i++) begin
            n_q[i] = r_q[i];
        end
        if (w_pop) begin
            for (int i = 0; i < 3; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        if (w_nres != 2'd0) n_q[base[1:0]] = w_res[0];
        if (w_nres == 2'd2) n_q[base[1:0] + 2'd1] = w_res[1];
        n_cnt = base + {1'b0, w_nres};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_start    <= '0;
            r_col      <= '0;
            r_line     <= '0;
            r_kwp      <= KWP_RESET;
            r_dot      <= 1'b0;
            r_cnt      <= '0;
            r_in_valid <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_start    <= n_start;
            r_col      <= n_col;
            r_line     <= n_line;
            r_kwp      <= n_kwp;
            r_dot      <= n_dot;
            r_cnt      <= n_cnt;
            r_in_valid <= (i_valid && o_ready) || (r_in_valid && !w_proc);
        end
        if (i_valid && o_ready) begin
            r_in_req  <= i_req_type;
            r_in_char <= i_char_code;
        end
        for (int i = 0; i < 4; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    `SCT_ASSERT_NEXT(a_halt_holds,
        r_mode == MODE_HALTED && !(w_proc && r_in_req == REQ_EOF),
        r_mode == MODE_HALTED, "halted lexer left halt without end of file")
    `SCT_ASSERT_NOW(a_eof_shape, o_valid && o_token_kind == KIND_EOF,
        o_last_of_run && o_line_index == '0 && o_first_col == '0 && o_last_col == '0,
        "malformed end-of-file token")
    `SCT_ASSERT_NOW(a_err_shape, o_valid && o_token_kind == KIND_ERROR,
        o_error_code != ERR_NONE && o_last_col == o_first_col + 13'd1,
        "malformed error token")
    `SCT_ASSERT_NOW(a_err_only, o_valid && o_token_kind != KIND_ERROR,
        o_error_code == ERR_NONE, "error code on a non-error token")
    `SCT_ASSERT_NOW(a_q_bound, w_proc, r_cnt <= 3'd2 && n_cnt <= 3'd4,
        "token queue overflow")

endmodule

// ===== dv/token_checker.sv =====
`timescale 1ns / 100ps
// Token scoreboard for the source character tokenizer: mirrors the lexer on each
// accepted request and compares every token taken from the output channel.
// Depends on sct_pkg for widths, token kinds, error codes and the token record.
module token_checker
    import sct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_char_code,
    input  logic              i_tok_valid,
    input  logic              i_tok_ready,
    input  logic [3:0]        i_token_kind,
    input  logic [LINE_W-1:0] i_line_index,
    input  logic [COL_W-1:0]  i_first_col,
    input  logic [COL_W-1:0]  i_last_col,
    input  logic [1:0]        i_error_code,
    input  logic              i_last_of_run,
    output int                o_mismatch_count,
    output int                o_tokens_due
);

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_NUMBER,
        SCAN_MINUS,
        SCAN_HALTED
    } t_scan_mode;

    t_scan_mode        mode;
    logic [COL_W-1:0]  tok_first;
    logic [COL_W-1:0]  col;
    logic [LINE_W-1:0] line_no;
    int                word_len;
    logic [7:0]        word_chars [6];
    logic              has_dot;

    t_tok predicted_tokens [$];
    t_tok run_tokens [2];
    int   run_len;
    t_tok want;
    int   mismatch_count = 0;
    int   token_index = 0;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    task automatic clear_scan_state();
        mode      = SCAN_IDLE;
        tok_first = '0;
        col       = '0;
        line_no   = '0;
        word_len  = 0;
        has_dot   = 1'b0;
    endtask

    task automatic stage_token(input logic [3:0] tkind, input logic [LINE_W-1:0] tline,
                               input logic [COL_W-1:0] tfirst, input logic [COL_W-1:0] tlast,
                               input logic [1:0] terr);
        run_tokens[run_len].kind        = tkind;
        run_tokens[run_len].line        = tline;
        run_tokens[run_len].first       = tfirst;
        run_tokens[run_len].last        = tlast;
        run_tokens[run_len].err         = terr;
        run_tokens[run_len].last_of_run = 1'b0;
        run_len++;
    endtask

    task automatic raise_error(input logic [COL_W-1:0] at, input logic [1:0] code);
        stage_token(KIND_ERROR, line_no, at, at + COL_W'(1), code);
        mode = SCAN_HALTED;
    endtask

    task automatic extend_word(input logic [7:0] c);
        if (word_len < 6) word_chars[word_len] = c;
        if (word_len < 7) word_len++;
    endtask

    // keywords match only on exact length; stale letters past the length never count
    function automatic logic [3:0] word_kind();
        if (word_len == 3 && {word_chars[0], word_chars[1], word_chars[2]} == "fun")
            return KIND_FUN;
        if (word_len == 6 && {word_chars[0], word_chars[1], word_chars[2],
                              word_chars[3], word_chars[4], word_chars[5]} == "return")
            return KIND_RETURN;
        return KIND_IDENT;
    endfunction

    task automatic open_token(input logic [7:0] c, input logic [COL_W-1:0] at);
        mode = SCAN_IDLE;
        if (c inside {8'd32, [8'd9:8'd13]}) return;
        if (is_letter(c)) begin
            mode      = SCAN_WORD;
            tok_first = at;
            word_len  = 0;
            extend_word(c);
        end else if (is_numeral(c)) begin
            mode      = SCAN_NUMBER;
            tok_first = at;
            has_dot   = 1'b0;
        end else if (c == CH_MINUS) begin
            mode      = SCAN_MINUS;
            tok_first = at;
        end else begin
            case (c)
                CH_LPAREN: stage_token(KIND_LPAREN, line_no, at, at + COL_W'(1), ERR_NONE);
                CH_RPAREN: stage_token(KIND_RPAREN, line_no, at, at + COL_W'(1), ERR_NONE);
                CH_LBRACE: stage_token(KIND_LBRACE, line_no, at, at + COL_W'(1), ERR_NONE);
                CH_RBRACE: stage_token(KIND_RBRACE, line_no, at, at + COL_W'(1), ERR_NONE);
                CH_SEMI:   stage_token(KIND_SEMI, line_no, at, at + COL_W'(1), ERR_NONE);
                CH_COMMA:  stage_token(KIND_COMMA, line_no, at, at + COL_W'(1), ERR_NONE);
                default:   raise_error(at, ERR_CHAR);
            endcase
        end
    endtask

    task automatic close_pending();
        case (mode)
            SCAN_WORD:   stage_token(word_kind(), line_no, tok_first, col, ERR_NONE);
            SCAN_NUMBER: stage_token(has_dot ? KIND_FLOAT : KIND_INT, line_no, tok_first, col,
                                     ERR_NONE);
            SCAN_MINUS:  raise_error(tok_first, ERR_CHAR);
            default:     ;
        endcase
        if (mode != SCAN_HALTED) mode = SCAN_IDLE;
    endtask

    task automatic lex_request(input logic [1:0] req, input logic [7:0] c);
        run_len = 0;
        case (req)
            REQ_CHAR: begin
                if (mode != SCAN_HALTED) begin
                    case (mode)
                        SCAN_IDLE: open_token(c, col);
                        SCAN_WORD: begin
                            if (is_letter(c) || is_numeral(c)) begin
                                extend_word(c);
                            end else begin
                                stage_token(word_kind(), line_no, tok_first, col, ERR_NONE);
                                open_token(c, col);
                            end
                        end
                        SCAN_NUMBER: begin
                            if (c == CH_DOT) begin
                                if (has_dot) raise_error(col, ERR_DOT);
                                else has_dot = 1'b1;
                            end else if (!is_numeral(c)) begin
                                stage_token(has_dot ? KIND_FLOAT : KIND_INT, line_no, tok_first,
                                            col, ERR_NONE);
                                open_token(c, col);
                            end
                        end
                        SCAN_MINUS: begin
                            if (c == CH_GT) begin
                                stage_token(KIND_ARROW, line_no, tok_first, col + COL_W'(1),
                                            ERR_NONE);
                                mode = SCAN_IDLE;
                            end else begin
                                raise_error(tok_first, ERR_CHAR);
                            end
                        end
                        default: ;
                    endcase
                    if (col != COL_MAX) col++;
                end
            end
            REQ_EOL: begin
                if (mode != SCAN_HALTED) begin
                    close_pending();
                    if (mode != SCAN_HALTED) begin
                        if (line_no != LINE_MAX) line_no++;
                        col = '0;
                    end
                end
            end
            REQ_EOF: begin
                if (mode != SCAN_HALTED) close_pending();
                stage_token(KIND_EOF, '0, '0, '0, ERR_NONE);
                clear_scan_state();
            end
            default: ;
        endcase
        for (int i = 0; i < run_len; i++) begin
            if (i == run_len - 1) run_tokens[i].last_of_run = 1'b1;
            predicted_tokens.push_back(run_tokens[i]);
        end
    endtask

    task automatic compare_field(input string field, input int unsigned expv,
                                 input int unsigned actv);
        if (expv != actv) begin
            $display("%0t: token %0d %s expected %0d actual %0d", $time, token_index, field,
                     expv, actv);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan_state();
            predicted_tokens.delete();
        end else begin
            if (i_req_valid && i_req_ready) lex_request(i_req_type, i_char_code);
            if (i_tok_valid && i_tok_ready) begin
                if (predicted_tokens.size() == 0) begin
                    $display("%0t: token %0d arrived with none expected: kind %0d line %0d %0d..%0d",
                             $time, token_index, i_token_kind, i_line_index, i_first_col,
                             i_last_col);
                    mismatch_count++;
                end else begin
                    want = predicted_tokens.pop_front();
                    compare_field("kind", want.kind, i_token_kind);
                    compare_field("line", want.line, i_line_index);
                    compare_field("first_col", want.first, i_first_col);
                    compare_field("last_col", want.last, i_last_col);
                    compare_field("error_code", want.err, i_error_code);
                    compare_field("last_of_run", want.last_of_run, i_last_of_run);
                end
                token_index++;
            end
        end
        o_mismatch_count <= mismatch_count;
        o_tokens_due     <= predicted_tokens.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the tokenizer testbench: clock, reset, request stimulus, token sink
// stalls and the verdict. Depends on sct_pkg, source_char_tokenizer_top and token_checker.
module testbench;
    import sct_pkg::*;

    localparam int         CLK_PERIOD      = 12;
    localparam int         RESET_CYCLES    = 4;
    localparam int         RANDOM_ITEMS    = 1250;
    localparam int         LONG_HOLD       = 400;
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         RUN_LIMIT_NS    = 6_000_000;
    // the one request type the block ignores
    localparam logic [1:0] REQ_UNUSED      = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_req_type = REQ_CHAR;
    logic [7:0]        i_char_code = 8'd0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [3:0]        o_token_kind;
    logic [LINE_W-1:0] o_line_index;
    logic [COL_W-1:0]  o_first_col;
    logic [COL_W-1:0]  o_last_col;
    logic [1:0]        o_error_code;
    logic              o_last_of_run;

    int mismatch_count;
    int tokens_due;

    // requests_sent is shared by the request driver and the token sink; burst_left is the driver's own
    int requests_sent = 0;
    int burst_left = 0;

    string word_pool [12] = '{"fun", "return", "fu", "retur", "funn", "returns",
                              "f", "r", "re", "fUn", "x9", "ret2"};

    source_char_tokenizer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_token_kind (o_token_kind),
        .o_line_index (o_line_index),
        .o_first_col  (o_first_col),
        .o_last_col   (o_last_col),
        .o_error_code (o_error_code),
        .o_last_of_run(o_last_of_run)
    );

    token_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_req_type      (i_req_type),
        .i_char_code     (i_char_code),
        .i_tok_valid     (o_valid),
        .i_tok_ready     (i_ready),
        .i_token_kind    (o_token_kind),
        .i_line_index    (o_line_index),
        .i_first_col     (o_first_col),
        .i_last_col      (o_last_col),
        .i_error_code    (o_error_code),
        .i_last_of_run   (o_last_of_run),
        .o_mismatch_count(mismatch_count),
        .o_tokens_due    (tokens_due)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop: well beyond the slowest legal run, including both long hold-offs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Token sink: pick a stall style for a stretch of cycles, then another.
    // Twice during the run, hold off entirely for a long stretch so the token
    // queue fills and the block has to drop o_ready against a busy sender.
    initial begin : token_sink
        int          style;
        int          phase_left;
        int          holds_done;
        int          cycle;
        logic [15:0] stall_pattern;
        phase_left    = 0;
        holds_done    = 0;
        cycle         = 0;
        stall_pattern = 16'b1011_0111_0010_1101;
        style         = 0;
        forever begin
            @(negedge i_clk);
            cycle++;
            if ((holds_done == 0 && requests_sent >= 300) ||
                (holds_done == 1 && requests_sent >= 900)) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                holds_done++;
            end
            if (phase_left == 0) begin
                style      = $urandom_range(0, 3);
                phase_left = $urandom_range(8, 64);
            end
            phase_left--;
            case (style)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 3) != 0);
                2:       i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= stall_pattern[4'(cycle)];
            endcase
        end
    end

    // Offer one request and hold it until taken. Enter and leave at a falling edge.
    // Between bursts, drop valid for a random gap; some bursts follow with no gap.
    task automatic send_request(input logic [1:0] req, input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (req != REQ_UNUSED) requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_char(input logic [7:0] c);
        send_request(REQ_CHAR, c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        int unsigned idx;
        idx = $urandom_range(0, 51);
        return (idx < 26) ? 8'(65 + idx) : 8'(97 + idx - 26);
    endfunction

    function automatic logic [7:0] random_numeral();
        return 8'(48 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_blank();
        int unsigned v;
        v = $urandom_range(8, 13);
        return (v == 8) ? 8'd32 : 8'(v);
    endfunction

    function automatic logic [7:0] random_punct();
        case ($urandom_range(0, 5))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            4:       return CH_SEMI;
            default: return CH_COMMA;
        endcase
    endfunction

    // Identifier: half from keyword look-alikes, half letters then letters or digits.
    task automatic send_word();
        int n;
        if ($urandom_range(0, 1) == 0) begin
            send_text(word_pool[$urandom_range(0, 11)]);
        end else begin
            n = $urandom_range(0, 7);
            send_char(random_letter());
            repeat (n) send_char($urandom_range(0, 1) ? random_letter() : random_numeral());
        end
    endtask

    // Number: digits, maybe one dot and more digits; with two_dots, force the second-dot error.
    task automatic send_number(input bit two_dots);
        int n;
        n = $urandom_range(1, 4);
        repeat (n) send_char(random_numeral());
        if (two_dots || $urandom_range(0, 4) < 2) begin
            send_char(CH_DOT);
            n = $urandom_range(0, 3);
            repeat (n) send_char(random_numeral());
        end
        if (two_dots) send_char(CH_DOT);
    endtask

    // Mostly well-formed source text with random content; a little noise and
    // a few broken forms (lone minus, stray bytes, second dot, unused requests).
    task automatic send_source_fragment();
        int unsigned pick;
        int          n;
        pick = $urandom_range(0, 199);
        if (pick < 58) begin
            send_word();
        end else if (pick < 92) begin
            send_number(1'b0);
        end else if (pick < 110) begin
            send_char(CH_MINUS);
            send_char(CH_GT);
        end else if (pick < 140) begin
            send_char(random_punct());
        end else if (pick < 170) begin
            n = $urandom_range(1, 3);
            repeat (n) send_char(random_blank());
        end else if (pick < 190) begin
            send_request(REQ_EOL, 8'($urandom_range(0, 255)));
        end else if (pick < 192) begin
            send_char(CH_MINUS);
            send_char(8'($urandom_range(0, 255)));
        end else if (pick < 194) begin
            send_char(8'($urandom_range(0, 255)));
        end else if (pick < 196) begin
            send_number(1'b1);
        end else if (pick < 199) begin
            send_request(REQ_UNUSED, 8'($urandom_range(0, 255)));
        end else begin
            send_char(CH_MINUS);
            send_request(REQ_EOL, 8'd0);
        end
    endtask

    initial begin : request_source
        int random_end;
        int file_end;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: both keywords, every punctuation, arrow, int and float,
        // an identifier closed by end of line, then a second dot that halts
        // the block, a top byte and an unused request while halted, and end of file.
        send_text("fun(a,7)->{return 1.5;}x");
        send_request(REQ_EOL, 8'd0);
        send_text("9..");
        send_char(8'hFF);
        send_request(REQ_UNUSED, 8'hFF);
        send_request(REQ_EOF, 8'h00);

        // Random source files of random length, each closed by end of file.
        random_end = requests_sent + RANDOM_ITEMS;
        file_end   = requests_sent + $urandom_range(15, 80);
        while (requests_sent < random_end) begin
            send_source_fragment();
            if (requests_sent >= file_end) begin
                send_request(REQ_EOF, 8'($urandom_range(0, 255)));
                file_end = requests_sent + $urandom_range(15, 80);
            end
        end
        send_request(REQ_EOF, 8'd0);

        // Drain: release valid, wait for every predicted token, then allow a few
        // more cycles so a stray extra token would still be caught.
        i_valid <= 1'b0;
        while (tokens_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && tokens_due == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sct_pkg.sv
hw/rtl/source_char_tokenizer_top.sv
dv/token_checker.sv
dv/testbench.sv
